### src/mnet_pkg.sv
// mnet_pkg: types and constants shared by the note event transform
// no dependencies

package mnet_pkg;

   localparam int unsigned KindWidth = 2;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned RngWidth  = 32;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [KindWidth-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_NOTE_OFF = 2'd1;

   localparam logic [CsrIndexWidth-1:0] CSR_TRANSPOSE      = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_VELOCITY_SCALE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RANDOM_BIAS    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RNG_SEED       = 2'd3;

   localparam logic [RngWidth-1:0] LCG_MUL = 32'd1664525;
   localparam logic [RngWidth-1:0] LCG_ADD = 32'd1013904223;

   // floor(x / 100) = (x * 5243) >> 19 for x below 43690, larger x clamp to 127 anyway
   localparam logic [12:0] DIV100_MAGIC = 13'd5243;
   localparam int unsigned Div100Shift  = 19;
   // floor(x / 11) = (x * 0xBA2E8BA3) >> 35 for any 32-bit x
   localparam logic [31:0] DIV11_MAGIC  = 32'hBA2E8BA3;
   localparam int unsigned Div11Shift   = 35;

   localparam logic [6:0] PERCENT_FULL = 7'd100;
   localparam logic [7:0] DEFAULT_SCALE = 8'd100;
   localparam logic [6:0] NOTE_MAX = 7'd127;

   typedef struct packed {
      logic load_in;
      logic do_scale;
      logic do_div;
      logic step;
      logic do_mod;
      logic do_off;
      logic load_out;
   } mnet_cmd_type;

   typedef struct packed {
      logic rand_en;
      logic take;
   } mnet_sts_type;

endpackage

### src/mnet_if.sv
// mnet_req_if, mnet_rsp_if: valid/ready channels of the note event transform
// depends on mnet_pkg

interface mnet_req_if import mnet_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] event_kind;
   logic [ByteWidth-1:0] note_in;
   logic [ByteWidth-1:0] velocity_in;

   modport source (output valid, event_kind, note_in, velocity_in, input ready);
   modport sink   (input valid, event_kind, note_in, velocity_in, output ready);
endinterface

interface mnet_rsp_if import mnet_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] note_out;
   logic [ByteWidth-1:0] velocity_out;

   modport source (output valid, note_out, velocity_out, input ready);
   modport sink   (input valid, note_out, velocity_out, output ready);
endinterface

### src/mnet_ctrl.sv
// mnet_ctrl: sequencer of the note event transform
// depends on mnet_pkg; drives mnet_dp through mnet_cmd_type

module mnet_ctrl import mnet_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mnet_cmd_type cmd,
   input  mnet_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_STEP2,
      ST_MOD,
      ST_OFF,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.do_scale = 1'b1;
            cmd.step     = sts.rand_en;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.do_div = 1'b1;
            state_in   = (sts.rand_en && sts.take) ? ST_STEP2 : ST_WRITE;
         end
         ST_STEP2: begin
            cmd.step = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.do_mod = 1'b1;
            state_in   = ST_OFF;
         end
         ST_OFF: begin
            cmd.do_off = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/mnet_dp.sv
// mnet_dp: registers, generator and arithmetic of the note event transform
// depends on mnet_pkg; controlled by mnet_ctrl

module mnet_dp import mnet_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RngWidth-1:0]      csr_wdata,
   input  logic [KindWidth-1:0]     event_kind,
   input  logic [ByteWidth-1:0]     note_in,
   input  logic [ByteWidth-1:0]     velocity_in,
   output logic [ByteWidth-1:0]     note_out,
   output logic [ByteWidth-1:0]     velocity_out,
   input  mnet_cmd_type             cmd,
   output mnet_sts_type             sts
);

   logic signed [7:0] transpose_ff;
   logic [7:0]        scale_ff;
   logic [7:0]        bias_ff;
   logic [31:0]       rng_ff;

   logic [1:0]  kind_ff;
   logic [7:0]  note_ff, note_in_w;
   logic [7:0]  vel_ff;
   logic [15:0] prod_ff;
   logic [28:0] quot_ff;
   logic [7:0]  note_out_ff;
   logic [7:0]  vel_out_ff;

   logic [31:0]       lcg_next;
   logic signed [9:0] trans_sum;
   logic [6:0]        trans_clamped;
   logic [28:0]       div100_prod;
   logic [9:0]        vel_quot;
   logic [7:0]        vel_clamped;
   logic [37:0]       r_scaled;
   logic [38:0]       bias_scaled;
   logic [63:0]       div11_prod;
   logic [3:0]        rem11;
   logic signed [8:0] off_sum;
   logic [6:0]        off_clamped;
   logic              is_note;

   assign lcg_next = 32'(rng_ff * LCG_MUL + LCG_ADD);

   assign is_note = (kind_ff == KIND_NOTE_ON) || (kind_ff == KIND_NOTE_OFF);

   assign trans_sum = $signed({2'b00, note_ff}) + 10'(transpose_ff);
   always_comb begin
      if (trans_sum < 0) begin
         trans_clamped = '0;
      end else if (trans_sum > $signed({3'b000, NOTE_MAX})) begin
         trans_clamped = NOTE_MAX;
      end else begin
         trans_clamped = trans_sum[6:0];
      end
   end

   assign div100_prod = prod_ff * DIV100_MAGIC;
   assign vel_quot    = div100_prod[Div100Shift +: 10];
   always_comb begin
      if (vel_quot == '0) begin
         vel_clamped = 8'd1;
      end else if (vel_quot > {3'b000, NOTE_MAX}) begin
         vel_clamped = {1'b0, NOTE_MAX};
      end else begin
         vel_clamped = vel_quot[7:0];
      end
   end

   assign r_scaled    = rng_ff[31:1] * PERCENT_FULL;
   assign bias_scaled = {bias_ff, 31'd0};

   assign div11_prod = rng_ff * DIV11_MAGIC;
   assign rem11      = 4'(rng_ff[3:0] - 4'(quot_ff[3:0] * 4'd11));
   assign off_sum    = $signed({2'b00, note_ff[6:0]}) + $signed({5'b00000, rem11})
                       - 9'sd5;
   always_comb begin
      if (off_sum < 0) begin
         off_clamped = '0;
      end else if (off_sum > $signed({2'b00, NOTE_MAX})) begin
         off_clamped = NOTE_MAX;
      end else begin
         off_clamped = off_sum[6:0];
      end
   end

   assign sts.rand_en = (kind_ff == KIND_NOTE_ON) && (bias_ff != '0);
   assign sts.take    = ({1'b0, r_scaled} < bias_scaled);

   assign note_in_w = is_note ? {1'b0, trans_clamped} : note_ff;

   // configuration and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff <= '0;
         scale_ff     <= DEFAULT_SCALE;
         bias_ff      <= '0;
         rng_ff       <= 32'd1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TRANSPOSE:      transpose_ff <= $signed(csr_wdata[7:0]);
               CSR_VELOCITY_SCALE: scale_ff     <= csr_wdata[7:0];
               CSR_RANDOM_BIAS:    bias_ff      <= csr_wdata[7:0];
               CSR_RNG_SEED:       rng_ff       <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.step) begin
            rng_ff <= lcg_next;
         end
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         kind_ff <= event_kind;
         note_ff <= note_in;
         vel_ff  <= velocity_in;
      end
      if (cmd.do_scale) begin
         note_ff <= note_in_w;
         prod_ff <= vel_ff * scale_ff;
      end
      if (cmd.do_div && (kind_ff == KIND_NOTE_ON)) begin
         vel_ff <= vel_clamped;
      end
      if (cmd.do_mod) begin
         quot_ff <= div11_prod[Div11Shift +: 29];
      end
      if (cmd.do_off) begin
         note_ff <= {1'b0, off_clamped};
      end
      if (cmd.load_out) begin
         note_out_ff <= note_ff;
         vel_out_ff  <= vel_ff;
      end
   end

   assign note_out     = note_out_ff;
   assign velocity_out = vel_out_ff;

endmodule

### src/midi_note_event_transform.sv
// midi_note_event_transform: top level, transposes, scales and randomises note events
// depends on mnet_pkg, mnet_if, mnet_ctrl, mnet_dp
//
//   channel | role        | transaction
//   req     | event in    | event_kind, note_in, velocity_in
//   rsp     | event out   | note_out, velocity_out
//   csr     | write only  | csr_we, csr_index, csr_wdata
//
// an item runs through the scale, divide and write states, and through the step, mod and
// offset states when a random offset is taken (second generator step, multiply for mod 11,
// offset clamp); the sequencer takes one item at a time and req ready is high only in idle;
// the output register holds a result while the next item is processed
// a stalled rsp holds the sequencer in its write state until the output register frees
// synchronous reset: transpose 0, velocity scale 100, bias 0, generator state 1

module midi_note_event_transform import mnet_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   mnet_req_if.sink                 req_if,
   mnet_rsp_if.source               rsp_if,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RngWidth-1:0]      csr_wdata
);

   mnet_cmd_type cmd;
   mnet_sts_type sts;

   mnet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mnet_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .event_kind   (req_if.event_kind),
      .note_in      (req_if.note_in),
      .velocity_in  (req_if.velocity_in),
      .note_out     (rsp_if.note_out),
      .velocity_out (rsp_if.velocity_out),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

### bench/midi_note_event_transform_tb.sv
// midi_note_event_transform_tb: self-checking bench for the note event transform
// drives events and register writes, predicts each result and compares it field by field
// depends on mnet_pkg, mnet_if and midi_note_event_transform

module midi_note_event_transform_tb;
   import mnet_pkg::*;

   localparam logic [KindWidth-1:0] KIND_OTHER    = 2'd2;
   localparam logic [KindWidth-1:0] KIND_RESERVED = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES  = 80;

   typedef struct packed {
      logic [ByteWidth-1:0] note;
      logic [ByteWidth-1:0] velocity;
   } note_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [RngWidth-1:0]      csr_wdata;
   logic                     sink_ready = 1'b0;

   mnet_req_if req_bus ();
   mnet_rsp_if rsp_bus ();

   assign rsp_bus.ready = sink_ready;

   midi_note_event_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, mirrors the register file and generator
   logic signed [ByteWidth-1:0] cur_transpose = '0;
   logic [ByteWidth-1:0]        cur_scale     = DEFAULT_SCALE;
   logic [ByteWidth-1:0]        cur_bias      = '0;
   logic [RngWidth-1:0]         gen_state     = 32'd1;

   note_event_type predicted_events[$];

   int unsigned failures       = 0;
   int unsigned events_sent    = 0;
   int unsigned results_seen   = 0;
   int unsigned offsets_taken  = 0;
   int unsigned settings_loaded = 0;

   int unsigned burst_left  = 0;
   bit          sender_gaps = 1'b1;

   int unsigned hold_requests = 0;
   int unsigned holds_served  = 0;
   int unsigned hold_left     = 0;
   int unsigned pattern_left  = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  pattern_pos   = '0;

   function automatic logic [ByteWidth-1:0] clamp_pitch(input int value);
      if (value < 0) return '0;
      if (value > int'(NOTE_MAX)) return ByteWidth'(NOTE_MAX);
      return ByteWidth'(value);
   endfunction

   function automatic note_event_type transform_event(input logic [KindWidth-1:0] kind,
                                                      input logic [ByteWidth-1:0] note,
                                                      input logic [ByteWidth-1:0] velocity);
      note_event_type res;
      int unsigned scaled;
      int          offset;
      logic [63:0] frac_scaled;
      logic [63:0] bias_limit;
      res.note     = note;
      res.velocity = velocity;
      if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
         res.note = clamp_pitch(int'(note) + int'(cur_transpose));
         if (kind == KIND_NOTE_ON) begin
            scaled = (int'(velocity) * int'(cur_scale)) / int'(PERCENT_FULL);
            if (scaled < 1) scaled = 1;
            else if (scaled > int'(NOTE_MAX)) scaled = int'(NOTE_MAX);
            res.velocity = ByteWidth'(scaled);
            if (cur_bias != 0) begin
               gen_state   = gen_state * LCG_MUL + LCG_ADD;
               frac_scaled = 64'(gen_state[31:1]) * 64'd100;
               bias_limit  = 64'(cur_bias) << 31;
               if (frac_scaled < bias_limit) begin
                  gen_state = gen_state * LCG_MUL + LCG_ADD;
                  offset    = int'(gen_state % 32'd11) - 5;
                  res.note  = clamp_pitch(int'(res.note) + offset);
                  offsets_taken++;
               end
            end
         end
      end
      return res;
   endfunction

   // receiver: long hold-off on request, otherwise a rotating ready pattern
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         sink_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom());
               2: stall_pattern = 16'($urandom() & $urandom() & $urandom());
               default: stall_pattern = 16'($urandom() | $urandom());
            endcase
            if (stall_pattern == '0) stall_pattern = 16'h0001;
            pattern_left = $urandom_range(20, 200);
         end
         pattern_left--;
         sink_ready <= stall_pattern[pattern_pos];
         pattern_pos = pattern_pos + 1'b1;
      end
   end

   always @(posedge clock) begin
      note_event_type want;
      if (!reset && rsp_bus.valid && sink_ready) begin
         results_seen++;
         if (predicted_events.size() == 0) begin
            failures++;
            $display("%0t: unexpected transaction, expected none, got note %0d velocity %0d",
                     $time, rsp_bus.note_out, rsp_bus.velocity_out);
         end else begin
            want = predicted_events.pop_front();
            if (rsp_bus.note_out !== want.note) begin
               failures++;
               $display("%0t: note_out expected %0d, got %0d",
                        $time, want.note, rsp_bus.note_out);
            end
            if (rsp_bus.velocity_out !== want.velocity) begin
               failures++;
               $display("%0t: velocity_out expected %0d, got %0d",
                        $time, want.velocity, rsp_bus.velocity_out);
            end
         end
      end
   end

   task automatic send_event(input logic [KindWidth-1:0] kind,
                             input logic [ByteWidth-1:0] note,
                             input logic [ByteWidth-1:0] velocity);
      int unsigned gap;
      note_event_type expected;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.event_kind  <= kind;
      req_bus.note_in     <= note;
      req_bus.velocity_in <= velocity;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected = transform_event(kind, note, velocity);
      predicted_events = {predicted_events, expected};
      events_sent++;
   endtask

   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (predicted_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [RngWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_TRANSPOSE:      cur_transpose = data[7:0];
         CSR_VELOCITY_SCALE: cur_scale     = data[7:0];
         CSR_RANDOM_BIAS:    cur_bias      = data[7:0];
         CSR_RNG_SEED:       gen_state     = data;
         default: ;
      endcase
   endtask

   // upper bits of the byte registers carry noise, they must be ignored
   task automatic program_regs(input logic [7:0] transpose, input logic [7:0] scale,
                               input logic [7:0] bias, input logic [31:0] seed,
                               input bit load_seed);
      drain_block();
      write_csr(CSR_TRANSPOSE, {24'($urandom()), transpose});
      write_csr(CSR_VELOCITY_SCALE, {24'($urandom()), scale});
      write_csr(CSR_RANDOM_BIAS, {24'($urandom()), bias});
      if (load_seed) write_csr(CSR_RNG_SEED, seed);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic test_reset_defaults();
      send_event(KIND_NOTE_ON, 8'd60, 8'd100);
      send_event(KIND_NOTE_ON, 8'd0, 8'd0);
      send_event(KIND_NOTE_ON, 8'd255, 8'd255);
      send_event(KIND_NOTE_OFF, 8'd64, 8'd0);
      send_event(KIND_NOTE_OFF, 8'd200, 8'd255);
      send_event(KIND_OTHER, 8'hAB, 8'hCD);
      send_event(KIND_RESERVED, 8'hFF, 8'hFF);
   endtask

   task automatic test_register_extremes();
      program_regs(8'h80, 8'd0, 8'd0, 32'd0, 1'b0);
      send_event(KIND_NOTE_ON, 8'd127, 8'd255);
      send_event(KIND_NOTE_OFF, 8'd50, 8'd77);
      send_event(KIND_NOTE_ON, 8'd200, 8'd3);
      program_regs(8'h7F, 8'd255, 8'd255, 32'd0, 1'b1);
      send_event(KIND_NOTE_ON, 8'd10, 8'd50);
      send_event(KIND_NOTE_ON, 8'd127, 8'd1);
      send_event(KIND_NOTE_OFF, 8'd0, 8'd9);
      send_event(KIND_NOTE_ON, 8'd0, 8'd0);
      send_event(KIND_OTHER, 8'd0, 8'd0);
      program_regs(8'h00, 8'd100, 8'd100, 32'hFFFF_FFFF, 1'b1);
      repeat (4) send_event(KIND_NOTE_ON, 8'd2, 8'd127);
      send_event(KIND_NOTE_ON, 8'd125, 8'd64);
      program_regs(8'hF4, 8'd50, 8'd1, $urandom(), 1'b1);
      repeat (3) send_event(KIND_NOTE_ON, 8'd64, 8'd200);
   endtask

   task automatic test_backpressure();
      drain_block();
      hold_requests++;
      sender_gaps = 1'b0;
      repeat (24) send_event(KIND_NOTE_ON, 8'($urandom()), 8'($urandom()));
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
      logic [7:0] transpose;
      logic [7:0] scale;
      logic [7:0] bias;
      logic [KindWidth-1:0] kind;
      int unsigned roll;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: transpose = 8'h80;
            1: transpose = 8'h7F;
            default: transpose = 8'($urandom());
         endcase
         case ($urandom_range(0, 4))
            0: scale = 8'd0;
            1: scale = 8'd255;
            2: scale = DEFAULT_SCALE;
            default: scale = 8'($urandom());
         endcase
         case ($urandom_range(0, 4))
            0: bias = 8'd0;
            1: bias = 8'd255;
            2: bias = 8'd100;
            default: bias = 8'($urandom_range(1, 60));
         endcase
         program_regs(transpose, scale, bias, $urandom(), $urandom_range(0, 1) == 1);
         for (int i = 0; i < per_phase; i++) begin
            roll = $urandom_range(0, 19);
            if (roll < 10) kind = KIND_NOTE_ON;
            else if (roll < 15) kind = KIND_NOTE_OFF;
            else if (roll < 18) kind = KIND_OTHER;
            else kind = KIND_RESERVED;
            send_event(kind,
                       ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 127)),
                       8'($urandom()));
         end
      end
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.event_kind  = '0;
      req_bus.note_in     = '0;
      req_bus.velocity_in = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_phases(12, 120);
      drain_block();

      $display("%0d events sent over %0d register settings, %0d results compared",
               events_sent, settings_loaded, results_seen);
      $display("%0d random pitch offsets predicted, receiver held off %0d time(s)",
               offsets_taken, holds_served);
      if (failures == 0) begin
         $display("midi_note_event_transform: match");
      end else begin
         $display("midi_note_event_transform: mismatch");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, predicted_events.size());
      $display("midi_note_event_transform: mismatch");
      $finish;
   end

endmodule

### files.f
src/mnet_pkg.sv
src/mnet_if.sv
src/mnet_ctrl.sv
src/mnet_dp.sv
src/midi_note_event_transform.sv
bench/midi_note_event_transform_tb.sv
